// ----- rtl/wtps_pkg.sv -----
// ----------------------------------------------------------------------------
// wtps_pkg: shared types and constants of the weighted three-point smoother.
// Word formats and the record handed from the front end to the back end.
// ----------------------------------------------------------------------------
package wtps_pkg;

  localparam int unsigned DayBits = 9;
  localparam int unsigned WBits   = 19;  // Q3.16 weight, up to 2 * 2^16
  localparam int unsigned WFrac   = 16;

  // Kind of a job for the back end.
  typedef enum logic [1:0] {
    JOB_PASS   = 2'd0,  // emit middle unchanged
    JOB_SMOOTH = 2'd1,  // emit weighted mean of three samples
    JOB_NONE   = 2'd2   // nothing before the tail
  } job_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_MUL, BK_QUO, BK_OUT1, BK_OUT2
  } bk_state_e;

endpackage

// ----- rtl/wtps_if.sv -----
// ----------------------------------------------------------------------------
// wtps_in_if / wtps_out_if: valid/ready channels of the smoother.
// Each carries one word per handshake.
// ----------------------------------------------------------------------------
interface wtps_in_if #(parameter int unsigned VALUE_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [8:0]              day;
  logic signed [VALUE_BITS-1:0] sample;
  logic signed [VALUE_BITS-1:0] uncertainty;
  logic                    final_req;
  modport source (output valid, day, sample, uncertainty, final_req, input ready);
  modport sink   (input valid, day, sample, uncertainty, final_req, output ready);
endinterface

interface wtps_out_if #(parameter int unsigned VALUE_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [8:0]              out_day;
  logic signed [VALUE_BITS-1:0] smoothed;
  logic                    processed;
  logic                    end_of_series;
  modport source (output valid, out_day, smoothed, processed, end_of_series,
                  input ready);
  modport sink   (input valid, out_day, smoothed, processed, end_of_series,
                  output ready);
endinterface

// ----- rtl/wtps_div.sv -----
// ----------------------------------------------------------------------------
// wtps_div: unsigned restoring divider, one quotient bit per cycle.
// Shared by the reciprocal weights and the final quotient.
// ----------------------------------------------------------------------------
module wtps_div #(
  parameter int unsigned NB = 48,
  parameter int unsigned DB = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NB-1:0] num_i,
  input  logic [DB-1:0] den_i,
  output logic          done_o,
  output logic [NB-1:0] quo_o
);
  localparam int unsigned CB = $clog2(NB + 1);

  logic [NB-1:0] q_q, q_d;
  logic [DB:0]   r_q, r_d;
  logic [DB-1:0] dv_q, dv_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DB:0]   trial;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      q_d = num_i; r_d = '0; dv_d = den_i; cnt_d = CB'(NB); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {r_q[DB-1:0], q_q[NB-1]};
      if (trial >= {1'b0, dv_q}) begin
        r_d = trial - {1'b0, dv_q};
        q_d = {q_q[NB-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

// ----- rtl/wtps_front.sv -----
// ----------------------------------------------------------------------------
// wtps_front: series tracker. Holds the older and middle samples and turns
// each accepted word into one job record for the back end.
// ----------------------------------------------------------------------------
module wtps_front
  import wtps_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned JW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wtps_in_if.sink       in_if,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output logic [JW-1:0] job_o
);
  localparam int unsigned VB = VALUE_BITS;

  logic [DayBits-1:0] od_q, md_q;
  logic [VB-1:0]      ov_q, oe_q, mv_q, me_q;
  logic [1:0]         held_q;
  logic               take;
  job_kind_e          kind;

  assign in_if.ready = job_ready_i;
  assign take        = in_if.valid && job_ready_i;
  assign job_valid_o = in_if.valid;

  always_comb begin
    unique case (held_q)
      2'd0:    kind = JOB_NONE;
      2'd1:    kind = JOB_PASS;
      default: kind = JOB_SMOOTH;
    endcase
  end

  // Record: kind, final, older, middle, newest (day, value, error).
  assign job_o = {kind, in_if.final_req,
                  od_q, ov_q, oe_q, md_q, mv_q, me_q,
                  in_if.day, in_if.sample, in_if.uncertainty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'd0;
      od_q <= '0; ov_q <= '0; oe_q <= '0;
      md_q <= '0; mv_q <= '0; me_q <= '0;
    end else if (take) begin
      if (in_if.final_req) begin
        held_q <= 2'd0;
      end else begin
        od_q <= md_q; ov_q <= mv_q; oe_q <= me_q;
        md_q <= in_if.day; mv_q <= in_if.sample; me_q <= in_if.uncertainty;
        held_q <= (held_q != 2'd0) ? 2'd2 : 2'd1;
      end
    end
  end
endmodule

// ----- rtl/wtps_fifo.sv -----
// ----------------------------------------------------------------------------
// wtps_fifo: two-entry job queue between front end and back end.
// ----------------------------------------------------------------------------
module wtps_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ----- rtl/wtps_back.sv -----
// ----------------------------------------------------------------------------
// wtps_back: job executor. For a smoothing job it computes six reciprocals
// and one quotient on a shared serial divider; it emits up to two words per job.
// ----------------------------------------------------------------------------
module wtps_back
  import wtps_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned JW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  logic [JW-1:0] job_i,
  wtps_out_if.source    out_if
);
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned NB = WFrac + FRAC_BITS + 1;     // reciprocal numerator
  localparam int unsigned SB = WBits + 2;                  // sum of three weights
  localparam int unsigned PB = VB + WBits + 3;             // numerator sum width
  localparam int unsigned DN = (PB > NB) ? PB : NB;
  localparam int unsigned DD = (SB > VB + 1) ? SB : VB + 1;

  bk_state_e st_q, st_d;

  logic [JW-1:0]      j_q;
  logic [2:0]         idx_q;
  logic               first_q;
  logic [WBits-1:0]   w_q [3];
  logic [PB-1:0]      acc_q;
  logic               neg_q;
  logic [VB-1:0]      res_q;
  logic               start;
  logic [DN-1:0]      dnum;
  logic [DD-1:0]      dden;
  logic               ddone;
  logic [DN-1:0]      dquo;

  // Unpack the held job.
  logic [1:0]         kind_bits;
  job_kind_e          kind;
  logic               fin;
  logic [DayBits-1:0] dd [3];
  logic signed [VB-1:0] vv [3];
  logic signed [VB-1:0] ee [3];
  assign {kind_bits, fin, dd[0], vv[0], ee[0], dd[1], vv[1], ee[1],
          dd[2], vv[2], ee[2]} = j_q;
  assign kind = job_kind_e'(kind_bits);

  // Kind and final flag of the job waiting at the queue head.
  job_kind_e          new_kind;
  logic               new_fin;
  assign new_kind = job_kind_e'(job_i[JW-1 -: 2]);
  assign new_fin  = job_i[JW-3];

  // Divider operand for reciprocal step idx: even = day term, odd = error.
  logic [1:0]         wi;
  logic signed [DayBits:0] gap;
  logic [VB-1:0]      ae;
  logic [SB-1:0]      wsum;
  always_comb begin
    wi = idx_q[2:1];
    unique case (wi)
      2'd0:    gap = $signed({1'b0, dd[1]}) - $signed({1'b0, dd[0]});
      2'd2:    gap = $signed({1'b0, dd[2]}) - $signed({1'b0, dd[1]});
      default: gap = '0;
    endcase
    if (gap < 0) gap = '0;
    ae = ee[wi][VB-1] ? VB'(-ee[wi]) : VB'(ee[wi]);
    wsum = SB'(w_q[0]) + SB'(w_q[1]) + SB'(w_q[2]);
    if (st_q == BK_QUO) begin
      dnum = DN'(acc_q);
      dden = DD'(wsum);
    end else if (!idx_q[0]) begin
      dnum = DN'(1) << WFrac;
      dden = DD'(gap[DayBits-1:0]) + DD'(1);
    end else begin
      dnum = DN'(1) << (WFrac + FRAC_BITS);
      dden = DD'(ae) + (DD'(1) << FRAC_BITS);
    end
  end

  wtps_div #(.NB(DN), .DB(DD)) u_div (
    .clk_i, .rst_ni, .start_i(start), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  // Signed product of one term, accumulated as a magnitude with sign.
  logic signed [PB-1:0] prod, acc_s, acc_n;
  assign prod  = PB'(vv[idx_q[1:0]]) *
                 $signed({{(PB-WBits){1'b0}}, w_q[idx_q[1:0]]});
  assign acc_s = $signed(acc_q);
  assign acc_n = (idx_q == 3'd0) ? prod : acc_s + prod;

  logic job_take, out_take;
  assign job_take = (st_q == BK_IDLE) && job_valid_i;
  assign out_take = out_if.valid && out_if.ready;
  assign job_ready_o = st_q == BK_IDLE;

  always_comb begin
    st_d = st_q;
    start = 1'b0;
    unique case (st_q)
      BK_IDLE: if (job_valid_i) begin
        if (new_kind == JOB_SMOOTH) begin
          st_d = BK_DIV;
        end else if (new_kind == JOB_PASS) begin
          st_d = BK_OUT1;
        end else if (new_fin) begin
          st_d = BK_OUT2;
        end
      end
      BK_DIV:  begin
        start = first_q;
        if (ddone && idx_q == 3'd5) st_d = BK_MUL;
      end
      BK_MUL:  if (idx_q == 3'd2) st_d = BK_QUO;
      BK_QUO:  begin
        start = first_q;
        if (ddone) st_d = BK_OUT1;
      end
      BK_OUT1: if (out_take) st_d = fin ? BK_OUT2 : BK_IDLE;
      BK_OUT2: if (out_take) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  // first_q pulses in the cycle in which each divider start is raised, once the step
  // index already selects the operands of the next division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; idx_q <= '0; first_q <= 1'b0;
    end else begin
      st_q <= st_d;
      first_q <= (job_take && st_d == BK_DIV) ||
                 (st_q == BK_DIV && ddone && idx_q != 3'd5) ||
                 (st_q == BK_MUL && idx_q == 3'd2);
      if (job_take) idx_q <= '0;
      else if (st_q == BK_DIV && ddone) idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 1'b1;
      else if (st_q == BK_MUL) idx_q <= (idx_q == 3'd2) ? 3'd0 : idx_q + 1'b1;
    end
  end

  logic [WBits-1:0] rq;
  assign rq = WBits'(dquo);

  always_ff @(posedge clk_i) begin
    if (job_take) j_q <= job_i;
    if (st_q == BK_DIV && ddone) begin
      if (!idx_q[0]) w_q[wi] <= rq;
      else           w_q[wi] <= w_q[wi] + rq;
    end
    if (st_q == BK_MUL) begin
      if (idx_q == 3'd2) begin
        neg_q <= acc_n < 0;
        acc_q <= (acc_n < 0) ? PB'(-acc_n) : PB'(acc_n);
      end else begin
        acc_q <= PB'(acc_n);
      end
    end
    if (st_q == BK_QUO && ddone) res_q <= neg_q ? VB'(-dquo) : VB'(dquo);
  end

  always_comb begin
    out_if.valid = (st_q == BK_OUT1) || (st_q == BK_OUT2);
    if (st_q == BK_OUT1) begin
      out_if.out_day       = dd[1];
      out_if.smoothed      = (kind == JOB_SMOOTH) ? res_q : vv[1];
      out_if.processed     = kind == JOB_SMOOTH;
      out_if.end_of_series = 1'b0;
    end else begin
      out_if.out_day       = dd[2];
      out_if.smoothed      = vv[2];
      out_if.processed     = 1'b0;
      out_if.end_of_series = 1'b1;
    end
  end
endmodule

// ----- rtl/weighted_three_point_smoother_unit.sv -----
// ----------------------------------------------------------------------------
// weighted_three_point_smoother_unit: weighted three-point series smoother.
// Input words on in_if (day, sample, uncertainty, final_req); result words
// on out_if (out_day, smoothed, processed, end_of_series). Each sample is
// emitted once, one word late; the word with final_req also emits itself
// as the closing word of the series. The front end takes a word whenever
// the two-entry job queue has room, and the back end takes a job from the
// queue whenever it is idle. Every division runs on one shared serial
// divider, one quotient bit per cycle; with the default widths a division
// runs from its start through 38 quotient bits to done. A smoothing job
// runs six reciprocal divisions, three multiply-accumulate steps and the
// final quotient division before its word is offered. A pass-through job
// goes straight to its output word, a first sample that is not final emits
// nothing, and a closing word follows as a separate output word. Reset
// clears the held-sample count, the queue and the back end. When the
// receiver stalls, the output word holds steady until taken; the queue
// then fills and input stalls.
// ----------------------------------------------------------------------------
module weighted_three_point_smoother_unit
  import wtps_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wtps_in_if.sink     in_if,
  wtps_out_if.source  out_if
);
  // Job record: kind, final flag and three (day, value, error) triples.
  localparam int unsigned JW = 2 + 1 + 3 * (DayBits + 2 * VALUE_BITS);

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JW-1:0] fj, bj;

  wtps_front #(.VALUE_BITS(VALUE_BITS), .JW(JW)) u_front (
    .clk_i, .rst_ni, .in_if,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  wtps_fifo #(.W(JW)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  wtps_back #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS), .JW(JW)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .out_if
  );
endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted three-point smoother.
// Random and directed sample series go in through the input channel; a
// scoreboard predicts each result word and checks the results in order.
// Both sides insert random gaps, and the run includes one long output stall
// and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned VB = 16;
  localparam int unsigned FB = 8;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [8:0]           day;
    logic signed [VB-1:0] value;
    logic                 processed;
    logic                 eos;
  } res_word_t;

  // Smoothing predictor plus the queue of result words still owed by the block.
  class smooth_scoreboard;
    res_word_t owed[$];
    int        mismatches;
    logic [8:0]  old_day, mid_day;
    longint      old_val, old_err, mid_val, mid_err;
    int unsigned held;

    function longint weight(longint gap, longint err);
      longint g;
      longint e;
      g = (gap < 0) ? 0 : gap;
      e = (err < 0) ? -err : err;
      return (longint'(65536) / (1 + g)) +
             ((longint'(65536) <<< FB) / ((longint'(1) <<< FB) + e));
    endfunction

    function void note_sample(logic [8:0] d, logic signed [VB-1:0] v,
                              logic signed [VB-1:0] e, logic fin);
      res_word_t w;
      longint    wp, wc, wn, num, den;
      if (held == 1) begin
        w = '{mid_day, mid_val[VB-1:0], 1'b0, 1'b0};
        owed = {owed, w};
      end else if (held >= 2) begin
        wp = weight(longint'(mid_day) - longint'(old_day), old_err);
        wc = weight(0, mid_err);
        wn = weight(longint'(d) - longint'(mid_day), longint'(e));
        num = old_val * wp + mid_val * wc + longint'(v) * wn;
        den = wp + wc + wn;
        w = '{mid_day, VB'(num / den), 1'b1, 1'b0};
        owed = {owed, w};
      end
      if (fin) begin
        w = '{d, v, 1'b0, 1'b1};
        owed = {owed, w};
        held = 0;
      end else begin
        old_day = mid_day; old_val = mid_val; old_err = mid_err;
        mid_day = d; mid_val = longint'(v); mid_err = longint'(e);
        held = (held >= 1) ? 2 : 1;
      end
    endfunction

    function void check_word(res_word_t got);
      res_word_t exp_w;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_w = owed.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected day %0d value %0d proc %0b eos %0b",
                   exp_w.day, exp_w.value, exp_w.processed, exp_w.eos);
          $display("          got day %0d value %0d proc %0b eos %0b",
                   got.day, got.value, got.processed, got.eos);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  wtps_in_if  #(.VALUE_BITS(VB)) in_ch ();
  wtps_out_if #(.VALUE_BITS(VB)) out_ch ();

  weighted_three_point_smoother_unit #(.VALUE_BITS(VB), .FRAC_BITS(FB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  smooth_scoreboard sb = new();
  longint cycles = 0;
  bit     long_stall = 1'b0;  // set by the sender to hold the receiver off

  initial begin
    in_ch.valid = 1'b0;
    in_ch.day = '0;
    in_ch.sample = '0;
    in_ch.uncertainty = '0;
    in_ch.final_req = 1'b0;
    out_ch.ready = 1'b0;
  end

  // The cycle counter also serves as the timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one word, then waits for its handshake. Valid stays high after
  // the handshake; the next call or the caller drops it.
  task automatic send_word(logic [8:0] d, logic signed [VB-1:0] v,
                           logic signed [VB-1:0] e, logic fin, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.day <= d;
    in_ch.sample <= v;
    in_ch.uncertainty <= e;
    in_ch.final_req <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(d, v, e, fin);
  endtask

  task automatic send_random_series(int len, bit no_gap);
    logic [8:0] d;
    int i;
    d = 9'($urandom_range(1, 300));
    for (i = 0; i < len; i++) begin
      // Mostly rising days, sometimes a step back to exercise the gap clamp.
      if ($urandom_range(0, 9) == 0) d = 9'($urandom_range(1, 366));
      else d = (d + $urandom_range(0, 20) > 366) ? 9'd1 : 9'(d + $urandom_range(0, 20));
      send_word(d, VB'($urandom), VB'($urandom), i == len - 1, no_gap);
    end
  endtask

  // Receiver: random ready gaps, with one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_word('{out_ch.out_day, out_ch.smoothed, out_ch.processed,
                      out_ch.end_of_series});
  end

  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        out_ch.ready <= 1'b0;
        repeat (800) @(posedge clk_i);
        long_stall = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-sample series, field extremes, negative gaps.
    send_word(9'd1, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
    send_word(9'd366, -16'sd32768, 16'sh7FFF, 1'b0, 1'b0);
    send_word(9'd1, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_word(9'd366, -16'sd32768, 16'sd0, 1'b0, 1'b0);
    send_word(9'd200, 16'sh7FFF, -16'sd1, 1'b1, 1'b0);
    send_word(9'd10, 16'sd256, 16'sd0, 1'b0, 1'b0);
    send_word(9'd10, -16'sd256, 16'sd0, 1'b1, 1'b0);
    send_word(9'd5, 16'sd0, 16'sd256, 1'b0, 1'b0);
    send_word(9'd6, 16'sh5555, 16'shAAAA, 1'b0, 1'b0);
    send_word(9'd7, 16'shAAAA, 16'sh5555, 1'b0, 1'b0);
    send_word(9'd8, -16'sd1, 16'sd1, 1'b1, 1'b0);

    // Long output stall while words keep arriving back to back.
    long_stall = 1'b1;
    send_random_series(12, 1'b1);
    in_ch.valid <= 1'b0;

    // Pause until every owed result has been taken.
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    n = 0;
    while (n < 400) begin
      w_rand: begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        send_random_series(len, 1'b0);
        n += len;
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
